@@ hdl/ovn_pkg.sv @@
// Shared constants and codes for the octave value noise block.
package ovn_pkg;

    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_LENGTH_DEF  = 64;
    localparam int MAX_OCTAVES_DEF = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GRID_LENGTH  = 2'd1;
    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd2;
    localparam logic [1:0] REG_INVERSE_BIAS = 2'd3;

    localparam logic [6:0]  RST_GRID_WIDTH   = 7'd64;
    localparam logic [6:0]  RST_GRID_LENGTH  = 7'd64;
    localparam logic [3:0]  RST_OCTAVE_COUNT = 4'd4;
    localparam logic [15:0] RST_INVERSE_BIAS = 16'd16384;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [15:0] SCALE_ONE = 16'd32768;
    localparam logic [15:0] SCALE_MAX = 16'hFFFF;

endpackage

@@ hdl/octave_value_noise_2d.sv @@
// Multi-octave bilinear value noise over a seed grid, one shared divider and multiplier.
// Sequence: a write transaction updates the grid directly; a query runs the bit-serial divider
//   (6 + 6 steps to wrap x and y, 6, 6, 7, 16, 16 steps per octave with nonzero pitch, 7 steps
//   to normalize) and the single grid read port (4 reads per octave); octaves with zero pitch
//   are skipped.
// Throughput: one query at a time; writes are taken back to back while idle.
// Reset: synchronous, active low; registers return to their defaults, the grid is not cleared.
module octave_value_noise_2d
    import ovn_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [5:0]  i_pos_x,
    input  logic [5:0]  i_pos_y,
    input  logic [6:0]  i_seed_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_noise_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCT_W  = $clog2(MAX_OCTAVES) + 1;
    localparam int ACC_W  = 39 + OCT_W;
    localparam int SS_W   = 16 + OCT_W;
    localparam int DIV_W  = ACC_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_XMOD, S_YMOD, S_OCT, S_DX, S_DY, S_Y2, S_BX, S_BY,
        S_R0, S_R1, S_R2, S_R3, S_R4,
        S_MT, S_MB, S_MV, S_MS, S_MA, S_MW, S_MC, S_MN,
        S_FIN, S_DONE
    } t_state;

    t_state r_state;

    logic [6:0]  r_grid_width, r_grid_length;
    logic [3:0]  r_octave_count;
    logic [15:0] r_inverse_bias;

    logic [6:0] r_x, r_y, r_dx, r_dy, r_x1, r_x2, r_y1, r_y2;
    logic [3:0] r_oct;
    logic [15:0] r_bx, r_by, r_scale;
    logic [6:0] r_c11, r_c21, r_c12, r_c22;
    logic signed [23:0] r_top, r_bot;
    logic [22:0] r_samp;
    logic [ACC_W-1:0] r_acc;
    logic [SS_W-1:0]  r_ssum;
    logic signed [41:0] r_prod;

    logic [DIV_W-1:0] r_rem, r_dsh;
    logic [15:0]      r_quo;
    logic [4:0]       r_div_cnt;

    logic       r_out_valid;
    logic [6:0] r_out_data;

    logic [6:0] r_mem [DEPTH];
    logic [6:0] r_rd_data;

    logic [6:0] w_eff, len_eff, p;
    logic [3:0] oct_eff;
    logic       in_take, cfg_wr, mem_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [6:0] rd_row, rd_col;
    logic [7:0] xs, ys;
    logic [6:0] x1_n, y1_n;
    logic signed [7:0]  d_top, d_bot;
    logic signed [23:0] d_vert;
    logic signed [24:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [41:0] mul_p, samp_full;

    // Effective configuration, saturated into range
    always_comb begin
        if (r_grid_width == '0) w_eff = 7'd1;
        else if (int'(r_grid_width) > MAX_WIDTH) w_eff = 7'(MAX_WIDTH);
        else w_eff = r_grid_width;
        if (r_grid_length == '0) len_eff = 7'd1;
        else if (int'(r_grid_length) > MAX_LENGTH) len_eff = 7'(MAX_LENGTH);
        else len_eff = r_grid_length;
        if (r_octave_count == '0) oct_eff = 4'd1;
        else if (int'(r_octave_count) > MAX_OCTAVES) oct_eff = 4'(MAX_OCTAVES);
        else oct_eff = r_octave_count;
    end

    assign p       = w_eff >> r_oct;
    assign o_ready = (r_state == S_IDLE);
    assign in_take = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_noise_value = r_out_data;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        case (paddr[3:2])
            REG_GRID_WIDTH:   prdata = {25'd0, r_grid_width};
            REG_GRID_LENGTH:  prdata = {25'd0, r_grid_length};
            REG_OCTAVE_COUNT: prdata = {28'd0, r_octave_count};
            REG_INVERSE_BIAS: prdata = {16'd0, r_inverse_bias};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= RST_GRID_WIDTH;
            r_grid_length  <= RST_GRID_LENGTH;
            r_octave_count <= RST_OCTAVE_COUNT;
            r_inverse_bias <= RST_INVERSE_BIAS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_WIDTH:   r_grid_width   <= pwdata[6:0];
                REG_GRID_LENGTH:  r_grid_length  <= pwdata[6:0];
                REG_OCTAVE_COUNT: r_octave_count <= pwdata[3:0];
                REG_INVERSE_BIAS: r_inverse_bias <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Seed grid
    assign mem_we  = in_take && (i_func == FUNC_WRITE) && (int'(i_pos_x) < MAX_WIDTH)
                     && (int'(i_pos_y) < MAX_LENGTH);
    assign wr_addr = ADDR_W'(int'(i_pos_y) * MAX_WIDTH + int'(i_pos_x));

    always_comb begin
        case (r_state)
            S_R1:    begin rd_row = r_y1; rd_col = r_x2; end
            S_R2:    begin rd_row = r_y2; rd_col = r_x1; end
            S_R3:    begin rd_row = r_y2; rd_col = r_x2; end
            default: begin rd_row = r_y1; rd_col = r_x1; end
        endcase
    end
    assign rd_addr = ADDR_W'(int'(rd_row) * MAX_WIDTH + int'(rd_col));

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= i_seed_value;
        r_rd_data <= r_mem[rd_addr];
    end

    // Lattice corners from the divider remainder
    assign x1_n = r_x - r_rem[6:0];
    assign y1_n = r_y - r_rem[6:0];
    assign xs   = {1'b0, x1_n} + {1'b0, p};
    assign ys   = {1'b0, y1_n} + {1'b0, p};

    // Shared multiplier operand select
    assign d_top  = $signed({1'b0, r_c21}) - $signed({1'b0, r_c11});
    assign d_bot  = $signed({1'b0, r_c22}) - $signed({1'b0, r_c12});
    assign d_vert = r_bot - r_top;
    always_comb begin
        case (r_state)
            S_MT:    begin mul_a = 25'(d_top);  mul_b = $signed({1'b0, r_bx}); end
            S_MB:    begin mul_a = 25'(d_bot);  mul_b = $signed({1'b0, r_bx}); end
            S_MS:    begin mul_a = 25'(d_vert); mul_b = $signed({1'b0, r_by}); end
            S_MW:    begin mul_a = $signed({2'b0, r_samp}); mul_b = $signed({1'b0, r_scale}); end
            S_MC:    begin mul_a = $signed({9'b0, r_scale});
                           mul_b = $signed({1'b0, r_inverse_bias}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p     = 42'(mul_a) * 42'(mul_b);
    assign samp_full = (r_prod >>> 16) + 42'(r_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) r_out_valid <= 1'b0;

            // Divider: one restoring step per cycle
            if (r_div_cnt != '0) begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_dsh     <= r_dsh >> 1;
                r_div_cnt <= r_div_cnt - 5'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take && i_func == FUNC_QUERY) begin
                        r_rem     <= DIV_W'(i_pos_x);
                        r_dsh     <= DIV_W'(w_eff) << 5;
                        r_quo     <= '0;
                        r_div_cnt <= 5'd6;
                        r_y       <= {1'b0, i_pos_y};
                        r_state   <= S_XMOD;
                    end
                end
                S_XMOD: begin
                    if (r_div_cnt == '0) begin
                        r_x       <= r_rem[6:0];
                        r_rem     <= DIV_W'(r_y);
                        r_dsh     <= DIV_W'(len_eff) << 5;
                        r_div_cnt <= 5'd6;
                        r_state   <= S_YMOD;
                    end
                end
                S_YMOD: begin
                    if (r_div_cnt == '0) begin
                        r_y     <= r_rem[6:0];
                        r_oct   <= '0;
                        r_scale <= SCALE_ONE;
                        r_acc   <= '0;
                        r_ssum  <= '0;
                        r_state <= S_OCT;
                    end
                end
                S_OCT: begin
                    if (r_oct == oct_eff) begin
                        r_rem     <= DIV_W'(r_acc);
                        r_dsh     <= DIV_W'(r_ssum) << 22;
                        r_div_cnt <= 5'd7;
                        r_state   <= S_FIN;
                    end else if (p == '0) begin
                        r_oct <= r_oct + 4'd1;
                    end else begin
                        r_rem     <= DIV_W'(r_x);
                        r_dsh     <= DIV_W'(p) << 5;
                        r_div_cnt <= 5'd6;
                        r_state   <= S_DX;
                    end
                end
                S_DX: begin
                    if (r_div_cnt == '0) begin
                        r_dx      <= r_rem[6:0];
                        r_x1      <= x1_n;
                        r_x2      <= (xs >= {1'b0, w_eff}) ? 7'(xs - {1'b0, w_eff}) : xs[6:0];
                        r_rem     <= DIV_W'(r_y);
                        r_dsh     <= DIV_W'(p) << 5;
                        r_div_cnt <= 5'd6;
                        r_state   <= S_DY;
                    end
                end
                S_DY: begin
                    if (r_div_cnt == '0) begin
                        r_dy      <= r_rem[6:0];
                        r_y1      <= y1_n;
                        // pitch may exceed the grid length several times over: full modulo
                        r_rem     <= DIV_W'(ys);
                        r_dsh     <= DIV_W'(len_eff) << 6;
                        r_div_cnt <= 5'd7;
                        r_state   <= S_Y2;
                    end
                end
                S_Y2: begin
                    if (r_div_cnt == '0) begin
                        r_y2      <= r_rem[6:0];
                        r_rem     <= DIV_W'({r_dx, 16'd0});
                        r_dsh     <= DIV_W'(p) << 15;
                        r_quo     <= '0;
                        r_div_cnt <= 5'd16;
                        r_state   <= S_BX;
                    end
                end
                S_BX: begin
                    if (r_div_cnt == '0) begin
                        r_bx      <= r_quo;
                        r_rem     <= DIV_W'({r_dy, 16'd0});
                        r_dsh     <= DIV_W'(p) << 15;
                        r_quo     <= '0;
                        r_div_cnt <= 5'd16;
                        r_state   <= S_BY;
                    end
                end
                S_BY: begin
                    if (r_div_cnt == '0) begin
                        r_by    <= r_quo;
                        r_state <= S_R0;
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_c11   <= r_rd_data;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_c21   <= r_rd_data;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_c12   <= r_rd_data;
                    r_state <= S_R4;
                end
                S_R4: begin
                    r_c22   <= r_rd_data;
                    r_state <= S_MT;
                end
                S_MT: begin
                    r_prod  <= mul_p;
                    r_state <= S_MB;
                end
                S_MB: begin
                    // take the upper row and launch the lower row product
                    r_top   <= $signed({1'b0, r_c11, 16'd0}) + 24'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_bot   <= $signed({1'b0, r_c12, 16'd0}) + 24'(r_prod);
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_prod  <= mul_p;
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_samp  <= samp_full[22:0];
                    r_state <= S_MW;
                end
                S_MW: begin
                    r_prod  <= mul_p;
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_acc   <= r_acc + ACC_W'(r_prod[38:0]);
                    r_ssum  <= r_ssum + SS_W'(r_scale);
                    r_prod  <= mul_p;
                    r_state <= S_MN;
                end
                S_MN: begin
                    r_scale <= (r_prod[41:31] != '0) ? SCALE_MAX : r_prod[30:15];
                    r_oct   <= r_oct + 4'd1;
                    r_state <= S_OCT;
                end
                S_FIN: begin
                    if (r_div_cnt == '0) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_quo[6:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_div_cnt == '0))
        else $error("divider running while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_func == FUNC_QUERY) |=> !o_ready)
        else $error("query did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_ssum != '0))
        else $error("zero scale sum at normalization");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_div_cnt == '0))
        else $error("result taken before division finished");

endmodule

@@ sim/ovn_noise_checker.sv @@
// Scoreboard for the octave value noise block: tracks grid and registers, predicts and compares.
`timescale 1ns / 100ps
module ovn_noise_checker
    import ovn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_func,
    input  logic [5:0]  i_pos_x,
    input  logic [5:0]  i_pos_y,
    input  logic [6:0]  i_seed_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [6:0]  i_noise_value,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    logic [6:0]  seed_grid [MAX_WIDTH_DEF * MAX_LENGTH_DEF];
    logic [6:0]  cfg_width;
    logic [6:0]  cfg_length;
    logic [3:0]  cfg_octaves;
    logic [15:0] cfg_inv_bias;
    logic [6:0]  noise_queue [$];
    int          error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = noise_queue.size();

    function automatic longint unsigned seed_at(int unsigned col, int unsigned row);
        return seed_grid[row * MAX_WIDTH_DEF + col];
    endfunction

    function automatic logic [6:0] predict_noise(int unsigned qx, int unsigned qy);
        int unsigned w, len, oct, p, x1, y1, x2, y2, x, y;
        longint unsigned bx, by, top, bot, samp, acc, scale_sum, scale;
        w   = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width;
        len = (cfg_length == 0) ? 1 :
              (cfg_length > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : cfg_length;
        oct = (cfg_octaves == 0) ? 1 :
              (cfg_octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : cfg_octaves;
        acc = 0;
        scale_sum = 0;
        scale = SCALE_ONE;
        x = qx % w;
        y = qy % len;
        for (int o = 0; o < oct; o++) begin
            p = w >> o;
            if (p == 0) continue;
            x1 = (x / p) * p;
            y1 = (y / p) * p;
            x2 = (x1 + p) % w;
            y2 = (y1 + p) % len;
            bx = (longint'(x - x1) << 16) / p;
            by = (longint'(y - y1) << 16) / p;
            top = (65536 - bx) * seed_at(x1, y1) + bx * seed_at(x2, y1);
            bot = (65536 - bx) * seed_at(x1, y2) + bx * seed_at(x2, y2);
            samp = ((65536 - by) * top + by * bot) >> 16;
            scale_sum += scale;
            acc += samp * scale;
            scale = (scale * cfg_inv_bias) >> 15;
            if (scale > SCALE_MAX) scale = SCALE_MAX;
        end
        if (scale_sum == 0) return '0;
        return 7'((acc / scale_sum) >> 16);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width    <= RST_GRID_WIDTH;
            cfg_length   <= RST_GRID_LENGTH;
            cfg_octaves  <= RST_OCTAVE_COUNT;
            cfg_inv_bias <= RST_INVERSE_BIAS;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_GRID_WIDTH:   cfg_width    <= i_pwdata[6:0];
                    REG_GRID_LENGTH:  cfg_length   <= i_pwdata[6:0];
                    REG_OCTAVE_COUNT: cfg_octaves  <= i_pwdata[3:0];
                    REG_INVERSE_BIAS: cfg_inv_bias <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) begin
                if (i_func == FUNC_WRITE)
                    seed_grid[i_pos_y * MAX_WIDTH_DEF + i_pos_x] = i_seed_value;
                else
                    noise_queue.push_back(predict_noise(i_pos_x, i_pos_y));
            end
            if (i_out_valid && i_out_ready) begin
                if (noise_queue.size() == 0)
                    report_mismatch($sformatf("unexpected noise %0d", i_noise_value));
                else if (noise_queue[0] !== i_noise_value) begin
                    report_mismatch($sformatf("noise_value got %0d want %0d",
                                              i_noise_value, noise_queue[0]));
                    void'(noise_queue.pop_front());
                end else
                    void'(noise_queue.pop_front());
            end
        end
    end

endmodule

@@ sim/octave_value_noise_2d_tb.sv @@
// Stimulus, clocking and verdict for the octave value noise block.
`timescale 1ns / 100ps
module octave_value_noise_2d_tb;
    import ovn_pkg::*;

    localparam int IDLE_CYCLES = 700;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = FUNC_WRITE;
    logic [5:0]  i_pos_x = '0;
    logic [5:0]  i_pos_y = '0;
    logic [6:0]  i_seed_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic [6:0]  o_noise_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int error_total;
    int noise_pending;
    int idle_mode = 0;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    int quiet_cycles = 0;
    int rand_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    octave_value_noise_2d uut (.*);

    ovn_noise_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_func(i_func),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_seed_value(i_seed_value),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_noise_value(o_noise_value),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(error_total), .o_pending(noise_pending)
    );

    always @(negedge i_clk) begin
        if (idle_mode == 2)
            i_ready <= ($urandom_range(0, 99) >= 58);
        else if (idle_mode == 3)
            i_ready <= ($urandom_range(0, 99) >= 14);
        else
            i_ready <= 1'b1;
    end

    // Abort when no transaction of any kind completes for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("octave_value_noise_2d_tb: FAIL");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic f, input logic [5:0] x, input logic [5:0] y,
                             input logic [6:0] v);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 58 : (idle_mode == 3) ? 14 : 0;
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func = f;
        i_pos_x = x;
        i_pos_y = y;
        i_seed_value = v;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Let everything drain, including write transactions that leave nothing to wait for
    task automatic drain_block();
        i_valid = 1'b0;
        while (noise_pending != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input int w, input int len, input int oct, input int ib);
        drain_block();
        reg_write(REG_GRID_WIDTH, w);
        reg_write(REG_GRID_LENGTH, len);
        reg_write(REG_OCTAVE_COUNT, oct);
        reg_write(REG_INVERSE_BIAS, ib);
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            idle_mode = (rand_count / 40) % 4;
            rand_count++;
            if ($urandom_range(0, 99) < 40)
                send_item(FUNC_QUERY, 6'($urandom), 6'($urandom), 7'($urandom));
            else
                send_item(FUNC_WRITE, 6'($urandom), 6'($urandom), 7'($urandom));
        end
        idle_mode = 0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Load the low 32x32 corner and every cell whose row and column are multiples of eight;
        // grids of up to 32x32, or 64x64 with pitch kept at eight or more, then read only loaded cells
        for (int r = 0; r < MAX_LENGTH_DEF; r++)
            for (int c = 0; c < MAX_WIDTH_DEF; c++)
                if ((r < 32 && c < 32) || (r % 8 == 0 && c % 8 == 0))
                    send_item(FUNC_WRITE, 6'(c), 6'(r), (r == 0 && c == 0) ? 7'd127 :
                              (r == 31 && c == 31) ? 7'd0 : 7'($urandom_range(1, 100)));

        // Reset defaults first, then corners and extreme seeds
        send_item(FUNC_QUERY, 6'd0, 6'd0, 7'd0);
        send_item(FUNC_QUERY, 6'd63, 6'd63, 7'd127);
        send_item(FUNC_QUERY, 6'd31, 6'd17, 7'd0);
        send_item(FUNC_WRITE, 6'd63, 6'd0, 7'd127);
        send_item(FUNC_WRITE, 6'd0, 6'd63, 7'd0);
        send_item(FUNC_QUERY, 6'd63, 6'd0, 7'd0);
        send_item(FUNC_QUERY, 6'd0, 6'd63, 7'd0);

        set_config(64, 64, 4, 65535);
        send_item(FUNC_QUERY, 6'd63, 6'd63, 7'd0);
        send_item(FUNC_QUERY, 6'd5, 6'd40, 7'd0);
        random_items(100);

        // Out-of-range registers saturate; single-cell grid
        set_config(0, 0, 0, 0);
        send_item(FUNC_QUERY, 6'd63, 6'd63, 7'd0);
        send_item(FUNC_QUERY, 6'd0, 6'd0, 7'd0);
        random_items(80);

        set_config(127, 127, 3, 32768);
        send_item(FUNC_QUERY, 6'd62, 6'd1, 7'd0);
        random_items(100);

        // Pitch drops to zero before the last octaves; row wrap on a short grid
        set_config(5, 3, 8, 16384);
        send_item(FUNC_QUERY, 6'd63, 6'd63, 7'd0);
        send_item(FUNC_QUERY, 6'd4, 6'd2, 7'd0);
        random_items(100);

        set_config(1, 32, 1, 1);
        random_items(80);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph[0])
                set_config($urandom_range(0, 32), $urandom_range(0, 32),
                           $urandom_range(0, 15), $urandom_range(0, 65535));
            else
                set_config($urandom_range(1, 32), $urandom_range(1, 32),
                           $urandom_range(1, 8), $urandom_range(8192, 40000));
            random_items(60);
        end

        drain_block();
        if (error_total == 0 && noise_pending == 0)
            $display("octave_value_noise_2d_tb: PASS");
        else
            $display("octave_value_noise_2d_tb: FAIL");
        $finish;
    end

endmodule
